/* rtl/core/fsg_pkg.sv */
package fsg_pkg;

  localparam logic [31:0] EMPTY_RGBA = 32'h0000_00ff;
  localparam int unsigned BRUSH_ODDS = 11;
  // A draw over 0..10 is zero exactly when the advanced state is below this bound.
  localparam logic [16:0] BRUSH_HIT_LIM = 17'((65536 + BRUSH_ODDS - 1) / BRUSH_ODDS);
  localparam logic [15:0] LFSR_TAPS = 16'hb400;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PLACE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_GRAVITY  = 2'd0,
    REG_INIT_VEL = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_SEED     = 2'd3
  } reg_idx_t;

  typedef enum logic [12:0] {
    S_CLR     = 13'b0_0000_0000_0001,
    S_IDLE    = 13'b0_0000_0000_0010,
    S_T1_RD   = 13'b0_0000_0000_0100,
    S_T1_CHK  = 13'b0_0000_0000_1000,
    S_T1_TGT  = 13'b0_0000_0001_0000,
    S_T1_DIAG = 13'b0_0000_0010_0000,
    S_T1_SWA  = 13'b0_0000_0100_0000,
    S_T1_SWB  = 13'b0_0000_1000_0000,
    S_T2_RD   = 13'b0_0001_0000_0000,
    S_T2_RUN  = 13'b0_0010_0000_0000,
    S_PL_CHK  = 13'b0_0100_0000_0000,
    S_PL_CELL = 13'b0_1000_0000_0000,
    S_DONE    = 13'b1_0000_0000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lfsr_ctrl_t;

endpackage

/* rtl/core/fsg_lfsr.sv */
module fsg_lfsr (
  input  logic              clk,
  input  logic              rst_n,
  input  fsg_pkg::lfsr_ctrl_t ctrl,
  input  logic [15:0]       seed,
  output logic [15:0]       peek
);

  logic [15:0] state_r;
  logic [15:0] state_nxt;

  assign peek = (state_r >> 1) ^ (state_r[0] ? fsg_pkg::LFSR_TAPS : 16'h0000);

  always_comb begin
    state_nxt = state_r;
    if (ctrl.load) begin
      state_nxt = (seed == 16'h0000) ? 16'h0001 : seed;
    end else if (ctrl.step) begin
      state_nxt = peek;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 16'h0001;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/fsg_grid_ram.sv */
module fsg_grid_ram #(
  parameter int AW = 16,
  parameter int DW = 49
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/falling_sand_grid_step.sv */
// Falling sand grid of ROWS x COLS cells held in one synchronous memory of colour and
// velocity. After reset the block sweeps the memory to empty, one cell a cycle, before it
// takes its first request. A tick first visits every cell, then moves each grain that can
// fall or tries a diagonal for it, and then runs a gravity pass over every cell; all of it
// goes through the single memory port pair. A place paints a square brush of side
// 2*radius+1 cells; a read returns the colour of one cell.
module falling_sand_grid_step #(
  parameter int ROWS = 256,
  parameter int COLS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[7:0], col[15:8], grain_rgba[47:16]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cell_rgba[31:0], brush_applied[32], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int VMAX = ROWS * 256;
  localparam int VW = $clog2(VMAX + 1);
  localparam int DW = 32 + VW;
  localparam logic [VW-1:0] VEL_MAX = VW'(VMAX);

  fsg_pkg::state_t state_r, state_nxt;
  logic [9:0]   gravity_r;
  logic [9:0]   init_vel_r;
  logic [4:0]   radius_r;
  logic [RW-1:0] r_r, r_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [31:0]  hc_r, hc_nxt;
  logic [VW-1:0] hv_r, hv_nxt;
  logic [DW-1:0] td_r, td_nxt;
  logic [7:0]   row_r, col_r;
  logic [31:0]  rgba_r;
  logic [1:0]   op_r;
  logic signed [11:0] br_r, br_nxt, bc_r, bc_nxt;
  logic [31:0]  res_rgba_r, res_rgba_nxt;
  logic         res_app_r, res_app_nxt;
  logic         out_valid_r;
  logic [32:0]  out_data_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [31:0]   rd_col;
  logic [VW-1:0] rd_vel;
  logic [15:0]   noise;
  fsg_pkg::lfsr_ctrl_t lfsr_ctrl;
  logic          accept, load_out;

  assign rd_col = rdata[DW-1:VW];
  assign rd_vel = rdata[VW-1:0];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == fsg_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out = (state_r == fsg_pkg::S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_data_r};

  function automatic logic [AW-1:0] cell_addr(input int r, input int c);
    cell_addr = AW'(r * COLS + c);
  endfunction

  fsg_grid_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  fsg_lfsr u_lfsr (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (lfsr_ctrl),
    .seed (cfg_data),
    .peek (noise)
  );

  always_comb begin
    int tr, dc, rad, here;
    logic [VW:0] vs;
    logic [VW-1:0] v0;
    state_nxt = state_r;
    r_nxt = r_r;
    c_nxt = c_r;
    tgt_nxt = tgt_r;
    hc_nxt = hc_r;
    hv_nxt = hv_r;
    td_nxt = td_r;
    br_nxt = br_r;
    bc_nxt = bc_r;
    res_rgba_nxt = res_rgba_r;
    res_app_nxt = res_app_r;
    we = 1'b0;
    waddr = tgt_r;
    wdata = {fsg_pkg::EMPTY_RGBA, VW'(0)};
    raddr = tgt_r;
    lfsr_ctrl.load = cfg_valid && (cfg_index == fsg_pkg::REG_SEED);
    lfsr_ctrl.step = 1'b0;
    rad = int'(radius_r);
    here = int'(cell_addr(int'(r_r), int'(c_r)));
    tr = int'(r_r) + int'(hv_r >> 8);
    dc = 0;
    vs = {1'b0, rd_vel} + (VW+1)'(gravity_r);
    v0 = (int'(init_vel_r) > VMAX) ? VEL_MAX : VW'(init_vel_r);
    unique case (state_r)
      fsg_pkg::S_CLR: begin
        we = 1'b1;
        tgt_nxt = tgt_r + 1'b1;
        if (int'(tgt_r) == DEPTH - 1) begin
          state_nxt = fsg_pkg::S_IDLE;
        end
      end
      fsg_pkg::S_IDLE: begin
        raddr = cell_addr(int'(in_tdata[7:0]), int'(in_tdata[15:8]));
        if (accept) begin
          res_rgba_nxt = 32'd0;
          res_app_nxt = 1'b0;
          state_nxt = fsg_pkg::S_DONE;
          if (in_tuser == fsg_pkg::OP_TICK) begin
            r_nxt = RW'(ROWS - 1);
            c_nxt = CW'(COLS - 1);
            state_nxt = fsg_pkg::S_T1_RD;
          end else if ((int'(in_tdata[7:0]) < ROWS) && (int'(in_tdata[15:8]) < COLS)) begin
            if (in_tuser == fsg_pkg::OP_PLACE) begin
              state_nxt = fsg_pkg::S_PL_CHK;
            end else if (in_tuser == fsg_pkg::OP_READ) begin
              state_nxt = fsg_pkg::S_T2_RUN;
              tgt_nxt = '0;
            end
          end
        end
      end
      fsg_pkg::S_T1_RD: begin
        raddr = AW'(here);
        state_nxt = fsg_pkg::S_T1_CHK;
      end
      fsg_pkg::S_T1_CHK: begin
        hc_nxt = rd_col;
        hv_nxt = rd_vel;
        tr = int'(r_r) + int'(rd_vel >> 8);
        if ((rd_col != fsg_pkg::EMPTY_RGBA) && (rd_vel != '0) && (tr < ROWS)) begin
          tgt_nxt = cell_addr(tr, int'(c_r));
          raddr = cell_addr(tr, int'(c_r));
          state_nxt = fsg_pkg::S_T1_TGT;
        end else begin
          state_nxt = fsg_pkg::S_T1_SWB;
        end
      end
      fsg_pkg::S_T1_TGT: begin
        if (rd_col == fsg_pkg::EMPTY_RGBA) begin
          td_nxt = rdata;
          state_nxt = fsg_pkg::S_T1_SWA;
        end else begin
          lfsr_ctrl.step = 1'b1;
          dc = noise[0] ? int'(c_r) + 1 : int'(c_r) - 1;
          if ((int'(r_r) + 1 < ROWS) && (dc >= 0) && (dc < COLS)) begin
            tgt_nxt = cell_addr(int'(r_r) + 1, dc);
            raddr = cell_addr(int'(r_r) + 1, dc);
            state_nxt = fsg_pkg::S_T1_DIAG;
          end else begin
            state_nxt = fsg_pkg::S_T1_SWB;
          end
        end
      end
      fsg_pkg::S_T1_DIAG: begin
        td_nxt = rdata;
        state_nxt = (rd_col == fsg_pkg::EMPTY_RGBA) ? fsg_pkg::S_T1_SWA : fsg_pkg::S_T1_SWB;
      end
      fsg_pkg::S_T1_SWA: begin
        we = 1'b1;
        waddr = AW'(here);
        wdata = td_r;
        td_nxt = {hc_r, hv_r};
        hc_nxt = fsg_pkg::EMPTY_RGBA;
        state_nxt = fsg_pkg::S_T1_SWB;
      end
      fsg_pkg::S_T1_SWB: begin
        // The second half of a swap; also the step to the next cell.
        we = (hc_r == fsg_pkg::EMPTY_RGBA) && (td_r[DW-1:VW] != fsg_pkg::EMPTY_RGBA);
        wdata = td_r;
        td_nxt = {fsg_pkg::EMPTY_RGBA, VW'(0)};
        state_nxt = fsg_pkg::S_T1_RD;
        if (c_r == '0) begin
          c_nxt = CW'(COLS - 1);
          r_nxt = r_r - 1'b1;
          if (r_r == '0) begin
            state_nxt = fsg_pkg::S_T2_RD;
          end
        end else begin
          c_nxt = c_r - 1'b1;
        end
      end
      fsg_pkg::S_T2_RD: begin
        tgt_nxt = AW'(DEPTH - 1);
        raddr = AW'(DEPTH - 1);
        state_nxt = fsg_pkg::S_T2_RUN;
      end
      fsg_pkg::S_T2_RUN: begin
        if (op_r == fsg_pkg::OP_READ) begin
          res_rgba_nxt = rd_col;
          state_nxt = fsg_pkg::S_DONE;
        end else begin
          we = (rd_col != fsg_pkg::EMPTY_RGBA);
          wdata = {rd_col, (vs > (VW+1)'(VMAX)) ? VEL_MAX : vs[VW-1:0]};
          tgt_nxt = tgt_r - 1'b1;
          raddr = tgt_r - 1'b1;
          if (tgt_r == '0) begin
            state_nxt = fsg_pkg::S_DONE;
          end
        end
      end
      fsg_pkg::S_PL_CHK: begin
        if (rd_col == fsg_pkg::EMPTY_RGBA) begin
          res_app_nxt = 1'b1;
          br_nxt = 12'(int'(row_r) - rad);
          bc_nxt = 12'(int'(col_r) - rad);
          state_nxt = fsg_pkg::S_PL_CELL;
        end else begin
          state_nxt = fsg_pkg::S_DONE;
        end
      end
      fsg_pkg::S_PL_CELL: begin
        if ((br_r >= 0) && (int'(br_r) < ROWS) && (bc_r >= 0) && (int'(bc_r) < COLS)) begin
          lfsr_ctrl.step = 1'b1;
          we = ({1'b0, noise} < fsg_pkg::BRUSH_HIT_LIM);
          waddr = cell_addr(int'(br_r), int'(bc_r));
          wdata = {rgba_r, v0};
        end
        if (int'(bc_r) == int'(col_r) + rad) begin
          bc_nxt = 12'(int'(col_r) - rad);
          br_nxt = br_r + 12'sd1;
          if (int'(br_r) == int'(row_r) + rad) begin
            state_nxt = fsg_pkg::S_DONE;
          end
        end else begin
          bc_nxt = bc_r + 12'sd1;
        end
      end
      fsg_pkg::S_DONE: begin
        if (load_out) begin
          state_nxt = fsg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fsg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsg_pkg::S_CLR;
      gravity_r <= 10'd26;
      init_vel_r <= 10'd0;
      radius_r <= 5'd10;
      tgt_r <= '0;
      out_valid_r <= 1'b0;
      hc_r <= fsg_pkg::EMPTY_RGBA;
      td_r <= {fsg_pkg::EMPTY_RGBA, VW'(0)};
    end else begin
      state_r <= state_nxt;
      tgt_r <= tgt_nxt;
      hc_r <= hc_nxt;
      td_r <= td_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          fsg_pkg::REG_GRAVITY:  gravity_r <= cfg_data[9:0];
          fsg_pkg::REG_INIT_VEL: init_vel_r <= cfg_data[9:0];
          fsg_pkg::REG_RADIUS:   radius_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    c_r <= c_nxt;
    hv_r <= hv_nxt;
    br_r <= br_nxt;
    bc_r <= bc_nxt;
    res_rgba_r <= res_rgba_nxt;
    res_app_r <= res_app_nxt;
    if (accept) begin
      row_r <= in_tdata[7:0];
      col_r <= in_tdata[15:8];
      rgba_r <= in_tdata[47:16];
      op_r <= in_tuser;
    end
    if (load_out) begin
      out_data_r <= {res_app_r, res_rgba_r};
    end
  end

endmodule

/* rtl/core/fsg_checker.sv */
module fsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity straight after reset");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("fill bits of the result are not zero");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("place result carries a colour");

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
